### rtl/srtp_irc_pkg.sv
// ----------------------------------------------------------------------------
// SRTP index estimate and replay check - shared package
// Request types, status codes, register indexes and field widths.
// ----------------------------------------------------------------------------
package srtp_irc_pkg;

    localparam int SEQ_W      = 16;
    localparam int ROC_W      = 32;
    localparam int PKT_IDX_W  = ROC_W + SEQ_W;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;

    // Half of the sequence space, the pivot of the rollover estimate
    localparam logic [SEQ_W-1:0] HALF_SEQ = 16'h8000;

    // Status codes
    localparam logic [1:0] ST_NEW    = 2'd0;
    localparam logic [1:0] ST_OLD    = 2'd1;
    localparam logic [1:0] ST_DUP    = 2'd2;
    localparam logic [1:0] ST_BYPASS = 2'd3;

    // Commands
    localparam logic CMD_CHECK  = 1'b0;
    localparam logic CMD_COMMIT = 1'b1;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_PROTECTION_ON = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_INITIAL_ROC   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_INITIAL_SEQ   = 2'd2;

    typedef struct packed {
        logic             command;
        logic [SEQ_W-1:0] seq_no;
    } t_in_req;

    typedef struct packed {
        logic                 accepted;
        logic [1:0]           status;
        logic [PKT_IDX_W-1:0] packet_index;
    } t_out_req;

endpackage

### rtl/srtp_irc_core.sv
// ----------------------------------------------------------------------------
// SRTP index estimate and replay check - classify and update logic
// Estimates the rollover counter, classifies one request and forms the
// next replay state.
// ----------------------------------------------------------------------------
module srtp_irc_core #(
    parameter int WINDOW_BITS = 64
) (
    input  srtp_irc_pkg::t_in_req                 i_req,
    input  logic                                  i_protection_on,
    input  logic [srtp_irc_pkg::ROC_W-1:0]        i_roc,
    input  logic [srtp_irc_pkg::SEQ_W-1:0]        i_highest_seq,
    input  logic [WINDOW_BITS-1:0]                i_mask,
    output srtp_irc_pkg::t_out_req                o_res,
    output logic [srtp_irc_pkg::ROC_W-1:0]        o_roc_nxt,
    output logic [srtp_irc_pkg::SEQ_W-1:0]        o_highest_seq_nxt,
    output logic [WINDOW_BITS-1:0]                o_mask_nxt
);

    localparam int          BIT_W = (WINDOW_BITS > 1) ? $clog2(WINDOW_BITS) : 1;
    localparam logic [17:0] WIN   = 18'(WINDOW_BITS);

    logic                               rel_dn;
    logic                               rel_up;
    logic [srtp_irc_pkg::ROC_W-1:0]     est_roc;
    logic [17:0]                        diff;
    logic [17:0]                        delta;
    logic [17:0]                        mag;
    logic                               newer;
    logic                               in_win;
    logic                               shift_in_win;
    logic                               seen;
    logic [1:0]                         status;
    logic [WINDOW_BITS-1:0]             mask_shift;
    logic [WINDOW_BITS-1:0]             mask_mark;

    // rollover estimate: one less when far above the highest, one more when far below
    assign rel_dn = !i_highest_seq[15]
                 && ({1'b0, i_req.seq_no} > ({1'b0, i_highest_seq}
                                              + {1'b0, srtp_irc_pkg::HALF_SEQ}));
    assign rel_up = i_highest_seq[15]
                 && ((i_highest_seq - srtp_irc_pkg::HALF_SEQ) > i_req.seq_no);

    assign est_roc = rel_up ? i_roc + 32'd1 :
                     rel_dn ? i_roc - 32'd1 : i_roc;

    // signed distance to the highest index, 18 bits two's complement
    assign diff  = {2'b00, i_req.seq_no} - {2'b00, i_highest_seq};
    assign delta = diff + (rel_up ? 18'h10000 : (rel_dn ? 18'h30000 : 18'h00000));
    assign mag   = 18'd0 - delta;

    assign newer        = !delta[17] && (delta != 18'd0);
    assign in_win       = !newer && (mag < WIN);
    assign shift_in_win = delta < WIN;
    assign seen         = in_win && i_mask[mag[BIT_W-1:0]];

    always_comb begin
        if (newer) begin
            status = srtp_irc_pkg::ST_NEW;
        end else if (!in_win) begin
            status = srtp_irc_pkg::ST_OLD;
        end else if (seen) begin
            status = srtp_irc_pkg::ST_DUP;
        end else begin
            status = srtp_irc_pkg::ST_NEW;
        end
        if (!i_protection_on) begin
            status = srtp_irc_pkg::ST_BYPASS;
        end
    end

    assign o_res.accepted     = (status == srtp_irc_pkg::ST_NEW)
                             || (status == srtp_irc_pkg::ST_BYPASS);
    assign o_res.status       = status;
    assign o_res.packet_index = {est_roc, i_req.seq_no};

    assign mask_shift = shift_in_win ? (i_mask << delta[BIT_W-1:0])
                                     : {WINDOW_BITS{1'b0}};
    assign mask_mark  = i_mask | (WINDOW_BITS'(1) << mag[BIT_W-1:0]);

    always_comb begin
        o_roc_nxt         = i_roc;
        o_highest_seq_nxt = i_highest_seq;
        o_mask_nxt        = i_mask;
        if (i_req.command == srtp_irc_pkg::CMD_COMMIT) begin
            if (newer) begin
                o_roc_nxt         = est_roc;
                o_highest_seq_nxt = i_req.seq_no;
                o_mask_nxt        = mask_shift | WINDOW_BITS'(1);
            end else if (in_win) begin
                o_mask_nxt        = mask_mark;
            end
        end
    end

endmodule

### rtl/srtp_index_estimate_replay_check_top.sv
// ----------------------------------------------------------------------------
// SRTP index estimate and replay check - top level
// Estimates the 48-bit packet index from a sequence number and classifies the
// packet against a sliding replay window; commits fold it into the window.
//
//   channel  | direction | handshake                    | payload
//   ---------+-----------+------------------------------+----------------------
//   in       | input     | i_in_valid / o_in_ready      | i_in_req  (t_in_req)
//   out      | output    | o_out_valid / i_out_ready    | o_out_req (t_out_req)
//   cfg      | input     | i_cfg_we (no wait)           | i_cfg_idx, i_cfg_wdata
//
// One request per cycle while the result is not stalled; a request passes
// through the input register, then the result register, and leaves from it.
// The state update (rollover counter, highest sequence, replay mask) happens
// as a request moves from the input register to the result register, so the
// next request always sees it.
// Reset is synchronous, active low: state goes to counter 0, sequence 0, empty
// mask, protection on. A stalled result holds the result register, and the
// input register then holds its request; input is refused only in that case.
// ----------------------------------------------------------------------------
module srtp_index_estimate_replay_check_top #(
    parameter int WINDOW_BITS = 64
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_in_valid,
    output logic                                   o_in_ready,
    input  srtp_irc_pkg::t_in_req                  i_in_req,
    output logic                                   o_out_valid,
    input  logic                                   i_out_ready,
    output srtp_irc_pkg::t_out_req                 o_out_req,
    input  logic                                   i_cfg_we,
    input  logic [srtp_irc_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [srtp_irc_pkg::CFG_DATA_W-1:0]    i_cfg_wdata
);

    // input register
    logic                               r_in_valid;
    srtp_irc_pkg::t_in_req              r_in_req;
    // result register
    logic                               r_out_valid;
    srtp_irc_pkg::t_out_req             r_out_req;
    // replay state and protection setting
    logic                               r_protection_on;
    logic [srtp_irc_pkg::ROC_W-1:0]     r_roc;
    logic [srtp_irc_pkg::SEQ_W-1:0]     r_highest_seq;
    logic [WINDOW_BITS-1:0]             r_mask;

    srtp_irc_pkg::t_out_req             n_out_req;
    logic [srtp_irc_pkg::ROC_W-1:0]     n_roc;
    logic [srtp_irc_pkg::SEQ_W-1:0]     n_highest_seq;
    logic [WINDOW_BITS-1:0]             n_mask;

    logic                               out_free;
    logic                               advance;

    // result register can load when empty or when its request leaves now
    assign out_free   = !r_out_valid || i_out_ready;
    assign advance    = r_in_valid && out_free;
    assign o_in_ready = !r_in_valid || out_free;

    srtp_irc_core #(
        .WINDOW_BITS (WINDOW_BITS)
    ) u_core (
        .i_req             (r_in_req),
        .i_protection_on   (r_protection_on),
        .i_roc             (r_roc),
        .i_highest_seq     (r_highest_seq),
        .i_mask            (r_mask),
        .o_res             (n_out_req),
        .o_roc_nxt         (n_roc),
        .o_highest_seq_nxt (n_highest_seq),
        .o_mask_nxt        (n_mask)
    );

    // handshake control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_in_ready) begin
                r_in_valid <= i_in_valid;
            end
            if (out_free) begin
                r_out_valid <= r_in_valid;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_in_req <= i_in_req;
        end
        if (advance) begin
            r_out_req <= n_out_req;
        end
    end

    // replay state: register writes must arrive only while idle, which the block
    // does not enforce (a write beats a commit); a write loads only its own state entry
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_protection_on <= 1'b1;
            r_roc           <= '0;
            r_highest_seq   <= '0;
            r_mask          <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                srtp_irc_pkg::REG_PROTECTION_ON: begin
                    r_protection_on <= i_cfg_wdata[0];
                end
                srtp_irc_pkg::REG_INITIAL_ROC: begin
                    r_roc <= i_cfg_wdata[srtp_irc_pkg::ROC_W-1:0];
                end
                srtp_irc_pkg::REG_INITIAL_SEQ: begin
                    r_highest_seq <= i_cfg_wdata[srtp_irc_pkg::SEQ_W-1:0];
                end
                default: begin
                    // unknown index: drop the write
                end
            endcase
        end else if (advance) begin
            r_roc         <= n_roc;
            r_highest_seq <= n_highest_seq;
            r_mask        <= n_mask;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_req   = r_out_req;

endmodule

### rtl/srtp_irc_checker.sv
// ----------------------------------------------------------------------------
// SRTP index estimate and replay check - port checker
// Watches the top level's ports and is bound to it.
// ----------------------------------------------------------------------------
module srtp_irc_checker (
    input logic                    i_clk,
    input logic                    i_rst_n,
    input logic                    i_in_valid,
    input logic                    o_in_ready,
    input logic                    o_out_valid,
    input logic                    i_out_ready,
    input srtp_irc_pkg::t_out_req  o_out_req
);

    // a result stalled by the sink stays offered
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid)
        else $error("result dropped while stalled");

    // accepted flag follows the status code
    a_accept_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_req.accepted ==
                         ((o_out_req.status == srtp_irc_pkg::ST_NEW)
                          || (o_out_req.status == srtp_irc_pkg::ST_BYPASS))))
        else $error("accepted flag does not match status");

    // input is refused only behind a stalled result
    a_ready_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_ready |-> o_out_valid)
        else $error("input refused with no pending result");

    // a fresh result comes from an accepted request that passed the input register
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(i_in_valid && o_in_ready && i_rst_n, 2))
        else $error("result appeared without a request");

endmodule

bind srtp_index_estimate_replay_check_top srtp_irc_checker u_srtp_irc_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_ready  (o_in_ready),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_req   (o_out_req)
);
